// ===== rtl/core/bdhr_pkg.sv =====
// Package for the button debounce, hold and auto-repeat core.
// Holds the mode and operation codes, the per-button control struct and the
// configuration register indexes and reset values. No dependencies.
package bdhr_pkg;

    // Width of the sample history and of the hold and repeat counters.
    localparam int HIST_W = 5;
    localparam int CNT_W  = 8;

    // Fixed field widths of the stream payload and of the configuration port.
    localparam int FUNC_W     = 2;
    localparam int FIELD_BTNS = 4;
    localparam int MODE_W     = 2;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    // History patterns: all samples high (released) and all samples low.
    localparam logic [HIST_W-1:0] HIST_ALL_HIGH = '1;
    localparam logic [HIST_W-1:0] HIST_ALL_LOW  = '0;

    // Configuration register indexes and their reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD  = 1'b1;
    localparam logic [CFG_W-1:0]     HOLD_THRESHOLD_RST = 8'd50;
    localparam logic [CFG_W-1:0]     REPEAT_PERIOD_RST  = 8'd10;

    // Debounced button mode.
    typedef enum logic [MODE_W-1:0] {
        MODE_RELEASED = 2'd0,
        MODE_PRESSED  = 2'd1,
        MODE_HELD     = 2'd2
    } t_mode;

    // Operation carried by an input item.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK        = 2'd0,
        FUNC_CLEAR_FLAGS = 2'd1,
        FUNC_RESET_BTN   = 2'd2,
        FUNC_NOP         = 2'd3
    } t_func;

    // Control for one button for one item.
    typedef struct packed {
        t_func func;
        logic  sample;
        logic  sel;
    } t_btn_ctrl;

    // Configuration shared by all buttons.
    typedef struct packed {
        logic [CFG_W-1:0] hold_threshold;
        logic [CFG_W-1:0] repeat_period;
    } t_cfg;

endpackage

// ===== rtl/core/bdhr_button.sv =====
// State and next-state logic of one debounced button.
// Depends on bdhr_pkg for the mode and operation codes and the control structs.
module bdhr_button
    import bdhr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_btn_ctrl i_ctrl,
    input  t_cfg      i_cfg,
    output t_mode     o_mode_next,
    output logic      o_flag_next
);

    logic [HIST_W-1:0] r_hist, n_hist;
    t_mode             r_mode, n_mode;
    logic [CNT_W-1:0]  r_hold, n_hold;
    logic [CNT_W-1:0]  r_rep,  n_rep;
    logic              r_flag, n_flag;
    logic [HIST_W-1:0] w_hist;

    // Next state for the operation of the current item.
    always_comb begin
        n_hist = r_hist;
        n_mode = r_mode;
        n_hold = r_hold;
        n_rep  = r_rep;
        n_flag = r_flag;
        w_hist = r_hist;
        case (i_ctrl.func)
            FUNC_TICK: begin
                if (r_mode == MODE_RELEASED) begin
                    // A low sample clears the newest history bit.
                    if (!i_ctrl.sample) begin
                        w_hist[0] = 1'b0;
                    end
                    if (w_hist == HIST_ALL_LOW) begin
                        n_hist = HIST_ALL_LOW;
                        n_mode = MODE_PRESSED;
                        n_flag = 1'b1;
                    end else begin
                        n_hist = {w_hist[HIST_W-2:0], 1'b1};
                    end
                end else begin
                    // A high sample sets the newest history bit.
                    w_hist[0] = w_hist[0] | i_ctrl.sample;
                    if (r_mode == MODE_PRESSED && w_hist == HIST_ALL_LOW) begin
                        if (r_hold >= i_cfg.hold_threshold) begin
                            n_mode = MODE_HELD;
                        end
                        n_hold = r_hold + 1'b1;
                    end
                    if (w_hist == HIST_ALL_HIGH) begin
                        // Release; the repeat counter keeps its value.
                        n_hist = HIST_ALL_HIGH;
                        n_mode = MODE_RELEASED;
                        n_hold = '0;
                    end else begin
                        n_hist = {w_hist[HIST_W-2:0], 1'b0};
                        // Auto-repeat while held, including the tick that entered held.
                        if (n_mode == MODE_HELD) begin
                            if (r_rep == i_cfg.repeat_period) begin
                                n_flag = 1'b1;
                                n_rep  = '0;
                            end else begin
                                n_rep = r_rep + 1'b1;
                            end
                        end
                    end
                end
            end
            FUNC_CLEAR_FLAGS: begin
                if (i_ctrl.sel) begin
                    n_flag = 1'b0;
                end
            end
            FUNC_RESET_BTN: begin
                if (i_ctrl.sel) begin
                    n_hist = HIST_ALL_HIGH;
                    n_mode = MODE_RELEASED;
                    n_hold = '0;
                    n_rep  = '0;
                    n_flag = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // State registers, updated once per processed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= HIST_ALL_HIGH;
            r_mode <= MODE_RELEASED;
            r_hold <= '0;
            r_rep  <= '0;
            r_flag <= 1'b0;
        end else if (i_en) begin
            r_hist <= n_hist;
            r_mode <= n_mode;
            r_hold <= n_hold;
            r_rep  <= n_rep;
            r_flag <= n_flag;
        end
    end

    assign o_mode_next = n_mode;
    assign o_flag_next = n_flag;

endmodule

// ===== rtl/core/button_debounce_hold_repeat_core.sv =====
// Top level of the button debounce core with hold detection and auto-repeat.
// Depends on bdhr_pkg and instantiates one bdhr_button per button.
//
// Usage:
//   Input stream (s_axis): one item per operation. tuser carries the
//   operation: tick with samples, clear press flags by mask, or reset
//   buttons by mask. tdata carries the active-low pin samples and the mask.
//   Output stream (m_axis): one item per input item, giving the mode of each
//   of the first four buttons and their sticky press flags after that operation.
//   Configuration: hold threshold and repeat period are written through
//   i_cfg_we / i_cfg_idx / i_cfg_data while the core is idle.
// Pipeline and throughput:
//   An accepted item is held in the input register; when it moves on, its
//   result is loaded into the result register.
//   One item per cycle is sustained while the receiver takes results.
// Reset and stall:
//   Reset (synchronous, active low) releases all buttons, clears flags and
//   counters and loads threshold 50 and period 10. When the receiver stalls,
//   the result register holds its item and the input register still takes
//   one more item; after that s_axis_tready drops until the result is taken.
module button_debounce_hold_repeat_core
    import bdhr_pkg::*;
#(
    parameter int NUM_BUTTONS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [3:0] samples, [7:4] button_mask
    input  logic [FUNC_W-1:0]     s_axis_tuser,  // [1:0] func
    // Output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [1:0] mode_button0, [3:2] mode_button1,
                                                 // [5:4] mode_button2, [7:6] mode_button3,
                                                 // [11:8] press_flags, [15:12] zero
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    t_cfg                      r_cfg;
    logic                      r_in_valid;
    t_func                     r_in_func;
    logic [FIELD_BTNS-1:0]     r_in_samples;
    logic [FIELD_BTNS-1:0]     r_in_mask;
    logic                      r_out_valid;
    logic [OUT_DATA_W-1:0]     r_out_data;
    logic                      w_advance;
    t_mode                     w_mode_next [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0]    w_flag_next;
    logic [FIELD_BTNS*MODE_W-1:0] w_modes;
    logic [FIELD_BTNS-1:0]     w_flags;

    // The buffered item moves on when the result register is free or being read.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_threshold <= HOLD_THRESHOLD_RST;
            r_cfg.repeat_period  <= REPEAT_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HOLD_THRESHOLD: r_cfg.hold_threshold <= i_cfg_data;
                CFG_REPEAT_PERIOD:  r_cfg.repeat_period  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_func    <= t_func'(s_axis_tuser);
            r_in_samples <= s_axis_tdata[FIELD_BTNS-1:0];
            r_in_mask    <= s_axis_tdata[2*FIELD_BTNS-1:FIELD_BTNS];
        end
    end

    // One state slice per button; buttons outside the fields sample high.
    for (genvar gi = 0; gi < NUM_BUTTONS; gi++) begin : g_btn
        t_btn_ctrl w_ctrl;
        t_mode     w_mode;
        logic      w_flag;

        if (gi < FIELD_BTNS) begin : g_in_field
            assign w_ctrl.sample = r_in_samples[gi];
            assign w_ctrl.sel    = r_in_mask[gi];
        end else begin : g_out_field
            assign w_ctrl.sample = 1'b1;
            assign w_ctrl.sel    = 1'b0;
        end
        assign w_ctrl.func = r_in_func;

        bdhr_button u_button (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (w_advance),
            .i_ctrl      (w_ctrl),
            .i_cfg       (r_cfg),
            .o_mode_next (w_mode),
            .o_flag_next (w_flag)
        );

        assign w_mode_next[gi] = w_mode;
        assign w_flag_next[gi] = w_flag;
    end

    // Report the first four buttons; missing buttons read as released, no flag.
    for (genvar gk = 0; gk < FIELD_BTNS; gk++) begin : g_report
        if (gk < NUM_BUTTONS) begin : g_present
            assign w_modes[gk*MODE_W +: MODE_W] = w_mode_next[gk];
            assign w_flags[gk]                  = w_flag_next[gk];
        end else begin : g_absent
            assign w_modes[gk*MODE_W +: MODE_W] = MODE_RELEASED;
            assign w_flags[gk]                  = 1'b0;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {{(OUT_DATA_W - FIELD_BTNS*MODE_W - FIELD_BTNS){1'b0}},
                           w_flags, w_modes};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A processed item always yields a result in the next cycle.
    a_advance_gives_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("processed item did not produce a result");

    // A buffered item that cannot move on is kept.
    a_item_kept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> r_in_valid)
        else $error("buffered item lost while stalled");

    // Resetting button 0 reports it released with its flag clear.
    a_reset_button0 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_func == FUNC_RESET_BTN && r_in_mask[0])
        |=> (r_out_data[MODE_W-1:0] == MODE_RELEASED && !r_out_data[FIELD_BTNS*MODE_W]))
        else $error("button reset not reflected in result");

    // Clearing flags by mask leaves button 0 without a press flag.
    a_clear_flag0 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_func == FUNC_CLEAR_FLAGS && r_in_mask[0])
        |=> !r_out_data[FIELD_BTNS*MODE_W])
        else $error("press flag clear not reflected in result");

endmodule
